[design/ecet_pkg.sv]
// Shared types, sizes and codes of the edge cost estimate table.
`timescale 1ns / 1ps

package ecet_pkg;

  // Table geometry
  localparam int LOCATIONS = 8;
  localparam int DOORS     = 32;
  localparam int LOC_W     = (LOCATIONS > 1) ? $clog2(LOCATIONS) : 1;
  localparam int DOOR_W    = $clog2(DOORS);
  localparam int ADDR_W    = LOC_W + 2 * DOOR_W;

  // Field widths
  localparam int ALPHA_W = 17;
  localparam int DCNT_W  = 6;
  localparam int EST_W   = 32;
  localparam int SAMP_W  = 16;
  localparam int LIM_W   = 9;

  // Divider sizes for the incremental mean
  localparam int NUM_W = 49;
  localparam int DEN_W = 17;

  // Request queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [ALPHA_W-1:0] ONE_Q16 = ALPHA_W'(65536);

  // Configuration register indexes
  localparam logic [1:0] CFG_ALPHA      = 2'd0;
  localparam logic [1:0] CFG_USE_EXP    = 2'd1;
  localparam logic [1:0] CFG_DOOR_COUNT = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_LOAD  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // Classified request: a rejected one carries OP_NOP with status set
  typedef struct packed {
    op_t                op;
    logic               status;
    logic [ADDR_W-1:0]  fwd_addr;
    logic [ADDR_W-1:0]  back_addr;
    logic [EST_W-1:0]   cost;
    logic [SAMP_W-1:0]  load_samples;
  } item_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha_eff;
    logic               use_exp;
  } cfg_t;

endpackage

[design/ecet_front.sv]
// Front end: configuration registers, request range check and classification.
`timescale 1ns / 1ps

module ecet_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [ecet_pkg::ALPHA_W-1:0] cfg_data,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [1:0]                  op,
  input  logic [2:0]                  location,
  input  logic [7:0]                  door_src,
  input  logic [7:0]                  door_to,
  input  logic [31:0]                 cost,
  input  logic [15:0]                 load_samples,
  input  logic                        q_full,
  input  logic                        clearing,
  output logic                        push,
  output ecet_pkg::item_t             push_item,
  output ecet_pkg::cfg_t              cfg
);

  logic [ecet_pkg::ALPHA_W-1:0] alpha;
  logic                         use_exponential;
  logic [ecet_pkg::DCNT_W-1:0]  door_count;

  logic [ecet_pkg::LIM_W-1:0] limit;
  logic                       bad;
  logic [ecet_pkg::LOC_W-1:0]  loc_idx;
  logic [ecet_pkg::DOOR_W-1:0] from_idx;
  logic [ecet_pkg::DOOR_W-1:0] to_idx;

  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha           <= ecet_pkg::ALPHA_W'(32768);
      use_exponential <= 1'b1;
      door_count      <= ecet_pkg::DCNT_W'(32);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ecet_pkg::CFG_ALPHA:      alpha           <= cfg_data;
        ecet_pkg::CFG_USE_EXP:    use_exponential <= cfg_data[0];
        ecet_pkg::CFG_DOOR_COUNT: door_count      <= cfg_data[ecet_pkg::DCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp alpha to one
  assign cfg.alpha_eff = (alpha > ecet_pkg::ONE_Q16) ? ecet_pkg::ONE_Q16 : alpha;
  assign cfg.use_exp   = use_exponential;

  // Check door and location indexes
  always_comb begin
    if (ecet_pkg::LIM_W'(door_count) < ecet_pkg::LIM_W'(ecet_pkg::DOORS)) begin
      limit = ecet_pkg::LIM_W'(door_count);
    end else begin
      limit = ecet_pkg::LIM_W'(ecet_pkg::DOORS);
    end
    bad = (ecet_pkg::LIM_W'(door_src) >= limit) ||
          (ecet_pkg::LIM_W'(door_to) >= limit) ||
          (ecet_pkg::LIM_W'(location) >= ecet_pkg::LIM_W'(ecet_pkg::LOCATIONS));
  end

  assign loc_idx  = ecet_pkg::LOC_W'(location);
  assign from_idx = ecet_pkg::DOOR_W'(door_src);
  assign to_idx   = ecet_pkg::DOOR_W'(door_to);

  // Classify the request
  always_comb begin
    push_item.fwd_addr     = {loc_idx, from_idx, to_idx};
    push_item.back_addr    = {loc_idx, to_idx, from_idx};
    push_item.cost         = cost;
    push_item.load_samples = load_samples;
    if (ecet_pkg::op_t'(op) == ecet_pkg::OP_NOP) begin
      push_item.op     = ecet_pkg::OP_NOP;
      push_item.status = 1'b0;
    end else if (bad) begin
      push_item.op     = ecet_pkg::OP_NOP;
      push_item.status = 1'b1;
    end else begin
      push_item.op     = ecet_pkg::op_t'(op);
      push_item.status = 1'b0;
    end
  end

  assign req_stall = q_full || clearing;
  assign push      = req_valid && !req_stall;

endmodule

[design/ecet_queue.sv]
// Short queue of classified requests between front and back.
`timescale 1ns / 1ps

module ecet_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ecet_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output ecet_pkg::item_t head
);

  ecet_pkg::item_t slots [ecet_pkg::QDEPTH];
  logic [ecet_pkg::QPTR_W-1:0] wr_ptr;
  logic [ecet_pkg::QPTR_W-1:0] rd_ptr;
  logic [ecet_pkg::QPTR_W:0]   fill;

  assign full  = (fill == (ecet_pkg::QPTR_W + 1)'(ecet_pkg::QDEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  // Store pushed requests
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

[design/ecet_div.sv]
// Restoring divider, one quotient bit per cycle, for the incremental mean.
`timescale 1ns / 1ps

module ecet_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ecet_pkg::NUM_W-1:0] num,
  input  logic [ecet_pkg::DEN_W-1:0] den,
  output logic                       done,
  output logic [ecet_pkg::NUM_W-1:0] quo
);

  localparam int STEP_W = $clog2(ecet_pkg::NUM_W);

  logic                       busy;
  logic [STEP_W-1:0]          step;
  logic [ecet_pkg::DEN_W-1:0] rem;
  logic [ecet_pkg::DEN_W-1:0] den_r;
  logic [ecet_pkg::DEN_W:0]   trial;
  logic [ecet_pkg::DEN_W:0]   diff;
  logic                       ge;

  // Shift in the next numerator bit and try a subtract
  always_comb begin
    trial = {rem, quo[ecet_pkg::NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= !start && busy && (step == STEP_W'(ecet_pkg::NUM_W - 1));
      if (start) begin
        busy  <= 1'b1;
        step  <= '0;
        rem   <= '0;
        den_r <= den;
        quo   <= num;
      end else if (busy) begin
        rem  <= ge ? diff[ecet_pkg::DEN_W-1:0] : trial[ecet_pkg::DEN_W-1:0];
        quo  <= {quo[ecet_pkg::NUM_W-2:0], ge};
        step <= step + 1'b1;
        if (step == STEP_W'(ecet_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

[design/ecet_back.sv]
// Back end: table memory, clearing pass, estimate update and result register.
`timescale 1ns / 1ps

module ecet_back (
  input  logic                       clk,
  input  logic                       rst,
  input  ecet_pkg::cfg_t             cfg,
  input  logic                       q_empty,
  input  ecet_pkg::item_t            head,
  output logic                       pop,
  output logic                       clearing,
  output logic                       res_valid,
  input  logic                       res_stall,
  output logic                       status,
  output logic [ecet_pkg::EST_W-1:0]  estimate,
  output logic [ecet_pkg::SAMP_W-1:0] samples
);

  localparam int EST_W  = ecet_pkg::EST_W;
  localparam int SAMP_W = ecet_pkg::SAMP_W;
  localparam int WORD_W = EST_W + SAMP_W;
  localparam int DEPTH  = 1 << ecet_pkg::ADDR_W;
  localparam int PROD_W = EST_W + ecet_pkg::ALPHA_W;
  localparam int ACC_W  = PROD_W + 1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_MUL2,
    S_SUM,
    S_RESOLVE,
    S_DIV,
    S_WR_FWD,
    S_WR_BACK,
    S_FINISH
  } state_t;

  state_t state;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data;
  logic              we;
  logic [ecet_pkg::ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;

  logic [ecet_pkg::ADDR_W-1:0] clear_addr;
  ecet_pkg::item_t             cur;
  logic [SAMP_W-1:0]           n;
  logic [EST_W-1:0]            new_est;
  logic [SAMP_W-1:0]           new_cnt;
  logic [PROD_W-1:0]           prod_a;
  logic [PROD_W-1:0]           prod_b;
  logic [ACC_W-1:0]            acc;

  logic [EST_W-1:0]            rd_est;
  logic [SAMP_W-1:0]           rd_cnt;
  logic [ecet_pkg::ALPHA_W-1:0] mul_b;
  logic [ecet_pkg::DEN_W-1:0]  n_plus;
  logic                        out_free;
  logic                        div_start;
  logic                        div_done;
  logic [ecet_pkg::NUM_W-1:0]  div_quo;

  // Saturate a wide unsigned value to the estimate width
  function automatic logic [EST_W-1:0] sat_est(input logic [ecet_pkg::NUM_W-1:0] v);
    logic [EST_W-1:0] r;
    r = (v[ecet_pkg::NUM_W-1:EST_W] != '0) ? '1 : v[EST_W-1:0];
    return r;
  endfunction

  assign rd_est   = rd_data[WORD_W-1:SAMP_W];
  assign rd_cnt   = rd_data[SAMP_W-1:0];
  assign mul_b    = cfg.use_exp ? (ecet_pkg::ONE_Q16 - cfg.alpha_eff)
                                : ecet_pkg::ALPHA_W'(rd_cnt);
  assign n_plus   = ecet_pkg::DEN_W'(n) + 1'b1;
  assign out_free = !res_valid || !res_stall;
  assign clearing = (state == S_CLEAR);
  assign pop      = (state == S_IDLE) && !q_empty;
  assign div_start = (state == S_RESOLVE) && !cfg.use_exp && (n != '0);

  // Select the memory write
  always_comb begin
    we      = 1'b0;
    wr_addr = cur.fwd_addr;
    wr_data = {new_est, new_cnt};
    case (state)
      S_CLEAR: begin
        we      = 1'b1;
        wr_addr = clear_addr;
        wr_data = '0;
      end
      S_WR_FWD: begin
        we = 1'b1;
      end
      S_WR_BACK: begin
        we      = 1'b1;
        wr_addr = cur.back_addr;
      end
      default: ;
    endcase
  end

  // Table memory with registered read of the current entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[cur.fwd_addr];
  end

  ecet_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (acc[ecet_pkg::NUM_W-1:0]),
    .den   (n_plus),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Sequence one request at a time and hold the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clear_addr <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && !res_stall && (state != S_FINISH)) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clear_addr <= clear_addr + 1'b1;
          if (clear_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            cur <= head;
            case (head.op)
              ecet_pkg::OP_LOAD: begin
                new_est <= head.cost;
                new_cnt <= head.load_samples;
                state   <= S_WR_FWD;
              end
              ecet_pkg::OP_NOP: begin
                new_est <= '0;
                new_cnt <= '0;
                state   <= S_FINISH;
              end
              default: state <= S_READ;
            endcase
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (cur.op == ecet_pkg::OP_QUERY) begin
            new_est <= rd_est;
            new_cnt <= rd_cnt;
            state   <= S_FINISH;
          end else begin
            n       <= rd_cnt;
            new_cnt <= (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;
            prod_a  <= PROD_W'(rd_est) * PROD_W'(mul_b);
            state   <= S_MUL2;
          end
        end
        S_MUL2: begin
          prod_b <= PROD_W'(cur.cost) * PROD_W'(cfg.alpha_eff);
          state  <= S_SUM;
        end
        S_SUM: begin
          if (cfg.use_exp) begin
            acc <= ACC_W'(prod_a) + ACC_W'(prod_b) + ACC_W'(32768);
          end else begin
            acc <= ACC_W'(prod_a) + ACC_W'(cur.cost) + ACC_W'(n_plus[ecet_pkg::DEN_W-1:1]);
          end
          state <= S_RESOLVE;
        end
        S_RESOLVE: begin
          if (cfg.use_exp) begin
            new_est <= sat_est(ecet_pkg::NUM_W'(acc[ACC_W-1:16]));
            state   <= S_WR_FWD;
          end else if (n == '0) begin
            new_est <= cur.cost;
            state   <= S_WR_FWD;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            new_est <= sat_est(div_quo);
            state   <= S_WR_FWD;
          end
        end
        S_WR_FWD: begin
          state <= (cur.op == ecet_pkg::OP_ADD) ? S_WR_BACK : S_FINISH;
        end
        S_WR_BACK: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            res_valid <= 1'b1;
            status    <= cur.status;
            estimate  <= new_est;
            samples   <= new_cnt;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[design/edge_cost_estimate_table.sv]
// Top level of the edge cost estimate table.
`timescale 1ns / 1ps

// Keeps a Q16.16 cost estimate and a sample count per (location, from-door,
// to-door) entry in one table memory. Requests are checked and queued (four
// deep) by the front end, so up to four can be taken while the back end works;
// the back end handles one request at a time and parks its result in an output
// register, moving on to the next request while that result waits. A nop or
// rejected request skips the table, a load writes the forward entry, a query
// reads it, an add reads it and writes both directions, and a mean add on a
// nonzero count waits for the restoring divider, one quotient bit per cycle.
// After reset a clearing pass zeroes all LOCATIONS * 2^(2*DOOR_W) entries
// (8192 here), one per cycle, with req_stall high; cfg writes are taken throughout.
module edge_cost_estimate_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  op,
  input  logic [2:0]  location,
  input  logic [7:0]  door_src,
  input  logic [7:0]  door_to,
  input  logic [31:0] cost,
  input  logic [15:0] load_samples,
  output logic        res_valid,
  input  logic        res_stall,
  output logic        status,
  output logic [31:0] estimate,
  output logic [15:0] samples
);

  logic            push;
  ecet_pkg::item_t push_item;
  ecet_pkg::item_t head;
  ecet_pkg::cfg_t  cfg;
  logic            q_full;
  logic            q_empty;
  logic            pop;
  logic            clearing;

  ecet_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .op           (op),
    .location     (location),
    .door_src     (door_src),
    .door_to      (door_to),
    .cost         (cost),
    .load_samples (load_samples),
    .q_full       (q_full),
    .clearing     (clearing),
    .push         (push),
    .push_item    (push_item),
    .cfg          (cfg)
  );

  ecet_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  ecet_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .clearing  (clearing),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .status    (status),
    .estimate  (estimate),
    .samples   (samples)
  );

endmodule

[design/ecet_checker.sv]
// Port-level checks of the edge cost estimate table, bound to the top level.
`timescale 1ns / 1ps

module ecet_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input logic        res_valid,
  input logic        res_stall,
  input logic        status,
  input logic [31:0] estimate,
  input logic [15:0] samples
);

  // Hold a stalled result
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(estimate) && $stable(samples) &&
    $stable(status))
    else $error("stalled result changed");

  // A rejected request reports zero fields
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && status |-> estimate == 32'd0 && samples == 16'd0)
    else $error("rejected request returned nonzero fields");

  // Reset drops any pending result
  a_reset_drop: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  // The clearing pass after reset blocks requests
  a_reset_stall: assert property (@(posedge clk)
    rst |=> req_stall)
    else $error("request accepted during clearing pass");

endmodule

bind edge_cost_estimate_table ecet_checker u_ecet_checker (.*);

[verif/tb_edge_cost_estimate_table.sv]
// Self-checking testbench of the edge cost estimate table.
`timescale 1ns / 1ps

module tb_edge_cost_estimate_table;

  // Index that names no register; writes to it must leave the setup alone
  localparam logic [1:0] CFG_NONE = 2'd3;
  localparam int unsigned ENTRIES = ecet_pkg::LOCATIONS * ecet_pkg::DOORS * ecet_pkg::DOORS;

  typedef struct {
    ecet_pkg::op_t op;
    logic [2:0]    loc;
    logic [7:0]    src;
    logic [7:0]    dst;
    logic [31:0]   cost;
    logic [15:0]   ls;
  } req_t;

  typedef struct {
    logic        status;
    logic [31:0] est;
    logic [15:0] samp;
  } resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [16:0] cfg_data = 17'd0;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [1:0]  op = 2'd0;
  logic [2:0]  location = 3'd0;
  logic [7:0]  door_src = 8'd0;
  logic [7:0]  door_to = 8'd0;
  logic [31:0] cost = 32'd0;
  logic [15:0] load_samples = 16'd0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic        status;
  logic [31:0] estimate;
  logic [15:0] samples;

  // Shadow of the table and of the setup registers
  logic [31:0] est_tbl [ENTRIES];
  logic [15:0] cnt_tbl [ENTRIES];
  logic [16:0] m_alpha = 17'd32768;
  logic        m_use_exp = 1'b1;
  logic [5:0]  m_door_count = 6'd32;

  req_t        req_q[$];
  resp_t       resp_q[$];
  req_t        cur;
  bit          sending = 1'b0;
  bit          req_done = 1'b0;
  bit          res_done = 1'b0;
  int unsigned gap_cnt = 0;
  int unsigned stall_cnt = 0;
  int unsigned calm_tx = 0;
  int unsigned calm_rx = 0;
  int          errors = 0;

  edge_cost_estimate_table uut (.*);

  always #5 clk = ~clk;

  // Fold one request into the shadow table and return the response it gives
  function automatic resp_t apply_request(req_t r);
    resp_t       rs;
    int unsigned lim, fwd, back;
    logic [63:0] a, acc, n, div;
    rs.status = 1'b0;
    rs.est = 32'd0;
    rs.samp = 16'd0;
    lim = (m_door_count < ecet_pkg::DOORS) ? m_door_count : ecet_pkg::DOORS;
    if (r.op != ecet_pkg::OP_NOP) begin
      if (r.src >= lim || r.dst >= lim || r.loc >= ecet_pkg::LOCATIONS) begin
        rs.status = 1'b1;
      end else begin
        fwd = (r.loc * ecet_pkg::DOORS + r.src) * ecet_pkg::DOORS + r.dst;
        back = (r.loc * ecet_pkg::DOORS + r.dst) * ecet_pkg::DOORS + r.src;
        case (r.op)
          ecet_pkg::OP_ADD: begin
            n = 64'(cnt_tbl[fwd]);
            if (m_use_exp) begin
              a = (m_alpha > ecet_pkg::ONE_Q16) ? 64'(ecet_pkg::ONE_Q16) : 64'(m_alpha);
              acc = ((64'(ecet_pkg::ONE_Q16) - a) * 64'(est_tbl[fwd]) + a * 64'(r.cost)
                     + 64'd32768) >> 16;
            end else if (n == 0) begin
              acc = 64'(r.cost);
            end else begin
              div = n + 1;
              acc = (64'(est_tbl[fwd]) * n + 64'(r.cost) + div / 2) / div;
            end
            rs.est = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
            rs.samp = (n >= 64'd65535) ? 16'hFFFF : 16'(n + 1);
            est_tbl[fwd] = rs.est;
            est_tbl[back] = rs.est;
            cnt_tbl[fwd] = rs.samp;
            cnt_tbl[back] = rs.samp;
          end
          ecet_pkg::OP_QUERY: begin
            rs.est = est_tbl[fwd];
            rs.samp = cnt_tbl[fwd];
          end
          default: begin
            rs.est = r.cost;
            rs.samp = r.ls;
            est_tbl[fwd] = r.cost;
            cnt_tbl[fwd] = r.ls;
          end
        endcase
      end
    end
    return rs;
  endfunction

  // Draw the wait for the next item, with calm stretches of no waiting
  task automatic draw_wait(inout int unsigned calm, output int unsigned cnt);
    if (calm > 0) begin
      calm--;
      cnt = 0;
    end else begin
      cnt = $urandom_range(0, 18);
      if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 40);
    end
  endtask

  // Drive requests from the pending queue, with a random gap after each
  always @(negedge clk) begin
    if (sending && req_done) begin
      sending = 1'b0;
      req_done = 1'b0;
      draw_wait(calm_tx, gap_cnt);
    end
    if (!sending && !rst) begin
      if (gap_cnt > 0) gap_cnt--;
      else if (req_q.size() != 0) begin
        cur = req_q.pop_front();
        sending = 1'b1;
      end
    end
    req_valid <= sending;
    op <= cur.op;
    location <= cur.loc;
    door_src <= cur.src;
    door_to <= cur.dst;
    cost <= cur.cost;
    load_samples <= cur.ls;
  end

  // Stall the result channel for a random number of cycles per result
  always @(negedge clk) begin
    if (res_done) begin
      res_done = 1'b0;
      draw_wait(calm_rx, stall_cnt);
    end
    if (res_valid && stall_cnt > 0) begin
      stall_cnt--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // Predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    resp_t want;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        resp_q.insert(resp_q.size(), apply_request(cur));
        req_done = 1'b1;
      end
      if (res_valid && !res_stall) begin
        res_done = 1'b1;
        if (resp_q.size() == 0) begin
          $display("%0t: result with none pending: status %0d estimate %h samples %0d",
                   $time, status, estimate, samples);
          errors++;
        end else begin
          want = resp_q.pop_front();
          if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            errors++;
          end
          if (estimate !== want.est) begin
            $display("%0t: estimate expected %h actual %h", $time, want.est, estimate);
            errors++;
          end
          if (samples !== want.samp) begin
            $display("%0t: samples expected %0d actual %0d", $time, want.samp, samples);
            errors++;
          end
        end
      end
    end
  end

  task automatic push(input ecet_pkg::op_t o, input int unsigned l, s, d,
                      input logic [31:0] c, input logic [15:0] n);
    req_t r;
    r.op = o;
    r.loc = l[2:0];
    r.src = s[7:0];
    r.dst = d[7:0];
    r.cost = c;
    r.ls = n;
    req_q.insert(req_q.size(), r);
  endtask

  // Hold until every queued request is sent and every response has come
  task automatic settle();
    do begin
      @(negedge clk);
      #1;
    end while (req_q.size() != 0 || sending || resp_q.size() != 0);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [16:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ecet_pkg::CFG_ALPHA:      m_alpha = val;
      ecet_pkg::CFG_USE_EXP:    m_use_exp = val[0];
      ecet_pkg::CFG_DOOR_COUNT: m_door_count = val[5:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random request: mostly valid doors in a few hot entries, some bad doors
  function automatic req_t rand_req();
    req_t        r;
    int unsigned lim, span, sel;
    lim = (m_door_count < ecet_pkg::DOORS) ? m_door_count : ecet_pkg::DOORS;
    span = ($urandom_range(0, 1) == 0 && lim > 3) ? 3 : lim;
    r.loc = ($urandom_range(0, 1) == 0) ? 3'($urandom_range(0, 1)) : 3'($urandom_range(0, 7));
    r.src = 8'($urandom_range(0, span - 1));
    r.dst = 8'($urandom_range(0, span - 1));
    sel = $urandom_range(0, 19);
    if (sel < 10) r.op = ecet_pkg::OP_ADD;
    else if (sel < 14) r.op = ecet_pkg::OP_QUERY;
    else if (sel < 17) r.op = ecet_pkg::OP_LOAD;
    else if (sel < 18) r.op = ecet_pkg::OP_NOP;
    else begin
      r.op = ecet_pkg::op_t'($urandom_range(0, 3));
      if (sel == 18) r.src = 8'($urandom_range(0, 255));
      else r.dst = 8'($urandom_range(0, 255));
    end
    case ($urandom_range(0, 7))
      0:       r.cost = 32'd0;
      1:       r.cost = 32'hFFFF_FFFF;
      2, 3:    r.cost = $urandom_range(0, 32'h0010_0000);
      default: r.cost = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0:       r.ls = 16'hFFFF;
      1:       r.ls = 16'($urandom_range(65530, 65535));
      2:       r.ls = 16'd0;
      default: r.ls = 16'($urandom);
    endcase
    return r;
  endfunction

  initial begin
    int ph;
    foreach (est_tbl[i]) begin
      est_tbl[i] = 32'd0;
      cnt_tbl[i] = 16'd0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset setup: cleared table, exponential add, mirror, same door, bad doors
    push(ecet_pkg::OP_QUERY, 0, 0, 0, 32'd0, 16'd0);
    push(ecet_pkg::OP_QUERY, 7, 31, 31, 32'hFFFF_FFFF, 16'hFFFF);
    push(ecet_pkg::OP_ADD, 1, 2, 5, 32'h0001_0000, 16'd0);
    push(ecet_pkg::OP_QUERY, 1, 5, 2, 32'd0, 16'd0);
    push(ecet_pkg::OP_ADD, 1, 2, 5, 32'hFFFF_FFFF, 16'd0);
    push(ecet_pkg::OP_ADD, 2, 3, 3, 32'd1000, 16'd0);
    push(ecet_pkg::OP_QUERY, 2, 3, 3, 32'd0, 16'd0);
    push(ecet_pkg::OP_LOAD, 3, 4, 6, 32'hFFFF_FFFF, 16'hFFFF);
    push(ecet_pkg::OP_QUERY, 3, 6, 4, 32'd0, 16'd0);
    push(ecet_pkg::OP_ADD, 3, 4, 6, 32'hFFFF_FFFF, 16'd0);
    push(ecet_pkg::OP_ADD, 4, 32, 0, 32'd5, 16'd0);
    push(ecet_pkg::OP_ADD, 4, 0, 255, 32'd5, 16'd0);
    push(ecet_pkg::OP_QUERY, 4, 255, 0, 32'd0, 16'd0);
    push(ecet_pkg::OP_LOAD, 4, 40, 1, 32'd7, 16'd7);
    push(ecet_pkg::OP_NOP, 5, 255, 255, 32'hFFFF_FFFF, 16'hFFFF);
    push(ecet_pkg::OP_ADD, 7, 31, 0, 32'd0, 16'd0);
    settle();

    // Incremental mean: first sample as is, ties up, count saturation
    write_cfg(ecet_pkg::CFG_USE_EXP, 17'd0);
    write_cfg(ecet_pkg::CFG_ALPHA, 17'd0);
    push(ecet_pkg::OP_ADD, 5, 1, 2, 32'd10, 16'd0);
    push(ecet_pkg::OP_ADD, 5, 1, 2, 32'd11, 16'd0);
    push(ecet_pkg::OP_ADD, 5, 2, 1, 32'd0, 16'd0);
    push(ecet_pkg::OP_LOAD, 6, 7, 8, 32'hFFFF_FFFF, 16'd65534);
    push(ecet_pkg::OP_ADD, 6, 7, 8, 32'hFFFF_FFFF, 16'd0);
    push(ecet_pkg::OP_ADD, 6, 7, 8, 32'd0, 16'd0);
    settle();

    // Alpha of one, above one, and zero
    write_cfg(ecet_pkg::CFG_USE_EXP, 17'd1);
    write_cfg(ecet_pkg::CFG_ALPHA, 17'd65536);
    push(ecet_pkg::OP_ADD, 1, 2, 5, 32'h1234_5678, 16'd0);
    settle();
    write_cfg(ecet_pkg::CFG_ALPHA, 17'h1FFFF);
    push(ecet_pkg::OP_ADD, 1, 2, 5, 32'd0, 16'd0);
    settle();
    write_cfg(ecet_pkg::CFG_ALPHA, 17'd0);
    push(ecet_pkg::OP_ADD, 1, 5, 2, 32'hFFFF_FFFF, 16'd0);
    settle();

    // Door limits: none valid, limit capped at the table size, single door
    write_cfg(ecet_pkg::CFG_DOOR_COUNT, 17'd0);
    push(ecet_pkg::OP_QUERY, 0, 0, 0, 32'd0, 16'd0);
    push(ecet_pkg::OP_LOAD, 0, 0, 0, 32'd9, 16'd9);
    settle();
    write_cfg(ecet_pkg::CFG_DOOR_COUNT, 17'd63);
    write_cfg(CFG_NONE, 17'h1FFFF);
    push(ecet_pkg::OP_QUERY, 1, 31, 31, 32'd0, 16'd0);
    push(ecet_pkg::OP_QUERY, 1, 32, 0, 32'd0, 16'd0);
    settle();
    write_cfg(ecet_pkg::CFG_DOOR_COUNT, 17'd1);
    push(ecet_pkg::OP_ADD, 0, 0, 0, 32'd3, 16'd0);
    push(ecet_pkg::OP_ADD, 0, 1, 0, 32'd3, 16'd0);
    settle();

    // Random phases, each under its own setup; the table drains between them
    for (ph = 0; ph < 8; ph++) begin
      write_cfg(ecet_pkg::CFG_USE_EXP, 17'(ph[0]));
      case ($urandom_range(0, 5))
        0:       write_cfg(ecet_pkg::CFG_ALPHA, 17'd0);
        1:       write_cfg(ecet_pkg::CFG_ALPHA, 17'd65536);
        2:       write_cfg(ecet_pkg::CFG_ALPHA, 17'h1FFFF);
        default: write_cfg(ecet_pkg::CFG_ALPHA, 17'($urandom_range(0, 131071)));
      endcase
      case ($urandom_range(0, 7))
        0:       write_cfg(ecet_pkg::CFG_DOOR_COUNT, 17'd1);
        1:       write_cfg(ecet_pkg::CFG_DOOR_COUNT, 17'd2);
        2:       write_cfg(ecet_pkg::CFG_DOOR_COUNT, 17'd31);
        3:       write_cfg(ecet_pkg::CFG_DOOR_COUNT, 17'd32);
        4:       write_cfg(ecet_pkg::CFG_DOOR_COUNT, 17'd33);
        5:       write_cfg(ecet_pkg::CFG_DOOR_COUNT, 17'd63);
        default: write_cfg(ecet_pkg::CFG_DOOR_COUNT, 17'($urandom_range(1, 63)));
      endcase
      repeat (125) req_q.insert(req_q.size(), rand_req());
      settle();
    end

    // Let any stray result show up before the verdict
    repeat (80) @(posedge clk);
    errors += resp_q.size();
    if (errors == 0) begin
      $display("tb_edge_cost_estimate_table OK");
    end else begin
      $display("tb_edge_cost_estimate_table NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("tb_edge_cost_estimate_table NOT OK");
    $finish;
  end

endmodule
